@@ hdl/glmp_pkg.sv @@
// ----------------------------------------------------------------------------
// glmp_pkg
// Shared types and constants of the linear move line parser: character
// tokens, parse phases and result verdicts.
// ----------------------------------------------------------------------------
package glmp_pkg;

  // Characters that the line grammar looks for.
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned CODE_W      = 7;
  localparam int unsigned FRAC_W      = 3;
  localparam logic [FRAC_W-1:0] FRAC_NEEDED = 3'd3;
  localparam logic [FRAC_W-1:0] FRAC_SAT    = 3'd7;
  localparam logic [CODE_W-1:0] CODE_LINEAR = 7'd1;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    TK_DIGIT = 4'd0,
    TK_N     = 4'd1,
    TK_G     = 4'd2,
    TK_X     = 4'd3,
    TK_Y     = 4'd4,
    TK_Z     = 4'd5,
    TK_MINUS = 4'd6,
    TK_POINT = 4'd7,
    TK_OTHER = 4'd8,
    TK_EOL   = 4'd9
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [1:0] {
    V_MOVE      = 2'd0,
    V_INVALID   = 2'd1,
    V_STOP      = 2'd2,
    V_UNDECIDED = 2'd3
  } verdict_e;

  typedef enum logic [12:0] {
    PH_EXP_N   = 13'b0000000000001,
    PH_N_FIRST = 13'b0000000000010,
    PH_N_MORE  = 13'b0000000000100,
    PH_G_FIRST = 13'b0000000001000,
    PH_G_MORE  = 13'b0000000010000,
    PH_X_START = 13'b0000000100000,
    PH_X_BODY  = 13'b0000001000000,
    PH_Y_START = 13'b0000010000000,
    PH_Y_BODY  = 13'b0000100000000,
    PH_Z_START = 13'b0001000000000,
    PH_Z_BODY  = 13'b0010000000000,
    PH_Z_DONE  = 13'b0100000000000,
    PH_SKIP    = 13'b1000000000000
  } phase_e;

endpackage

@@ hdl/glmp_classify.sv @@
// ----------------------------------------------------------------------------
// glmp_classify
// Front end: turns each incoming byte or line end into a token for the
// parser queue.
// ----------------------------------------------------------------------------
module glmp_classify (
  input  logic            char_valid_i,
  input  logic [7:0]      char_i,
  input  logic            line_done_i,
  input  logic            queue_full_i,
  output logic            char_ready_o,
  output logic            tok_push_o,
  output glmp_pkg::token_t tok_o
);
  import glmp_pkg::*;

  logic [7:0] digit_val;

  assign digit_val    = char_i - CH_ZERO;
  assign char_ready_o = !queue_full_i;
  assign tok_push_o   = char_valid_i && !queue_full_i;

  always_comb begin
    tok_o.digit = digit_val[3:0];
    if (line_done_i) begin
      tok_o.kind = TK_EOL;
    end else if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
      tok_o.kind = TK_DIGIT;
    end else begin
      unique case (char_i)
        CH_N:     tok_o.kind = TK_N;
        CH_G:     tok_o.kind = TK_G;
        CH_X:     tok_o.kind = TK_X;
        CH_Y:     tok_o.kind = TK_Y;
        CH_Z:     tok_o.kind = TK_Z;
        CH_MINUS: tok_o.kind = TK_MINUS;
        CH_POINT: tok_o.kind = TK_POINT;
        default:  tok_o.kind = TK_OTHER;
      endcase
    end
  end

endmodule

@@ hdl/glmp_queue.sv @@
// ----------------------------------------------------------------------------
// glmp_queue
// Short first-in first-out token queue between the classifier and the
// parser, with a fall-through read port.
// ----------------------------------------------------------------------------
module glmp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  glmp_pkg::token_t push_tok_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output glmp_pkg::token_t pop_tok_o
);
  import glmp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_tok_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

@@ hdl/glmp_exec.sv @@
// ----------------------------------------------------------------------------
// glmp_exec
// Back end: walks the line grammar one token per cycle, accumulates the
// decimal fields and loads the result register, when free, at each line end.
// ----------------------------------------------------------------------------
module glmp_exec #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned LINE_BITS  = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tok_valid_i,
  input  glmp_pkg::token_t      tok_i,
  output logic                  tok_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output glmp_pkg::verdict_e    res_verdict_o,
  output logic [LINE_BITS-1:0]  res_line_o,
  output logic [COORD_BITS-1:0] res_x_o,
  output logic [COORD_BITS-1:0] res_y_o,
  output logic [COORD_BITS-1:0] res_z_o,
  output logic                  res_gap_o
);
  import glmp_pkg::*;

  localparam int unsigned MAG_W = COORD_BITS - 1;
  localparam int unsigned LW4   = LINE_BITS + 4;
  localparam int unsigned MW4   = MAG_W + 4;
  localparam int unsigned CW4   = CODE_W + 4;

  phase_e                phase_q, phase_d;
  logic [LINE_BITS-1:0]  line_q, line_d;
  logic [LINE_BITS-1:0]  last_q, last_d;
  logic [CODE_W-1:0]     code_q, code_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  minus_q, minus_d;
  logic                  point_q, point_d;
  logic [FRAC_W-1:0]     frac_q, frac_d;
  logic [COORD_BITS-1:0] hx_q, hx_d;
  logic [COORD_BITS-1:0] hy_q, hy_d;
  logic                  gap_q, gap_d;
  verdict_e              verdict_q, verdict_d;
  logic                  halted_q, halted_d;

  logic                  out_valid_q, out_valid_d;
  verdict_e              out_verdict_q, out_verdict_d;
  logic [LINE_BITS-1:0]  out_line_q, out_line_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d;
  logic [COORD_BITS-1:0] out_y_q, out_y_d;
  logic [COORD_BITS-1:0] out_z_q, out_z_d;
  logic                  out_gap_q, out_gap_d;
  logic                  out_load;

  logic                  take;
  logic [LW4-1:0]        line_x10;
  logic [LINE_BITS-1:0]  line_next;
  logic [MW4-1:0]        mag_x10;
  logic [MAG_W-1:0]      mag_next;
  logic [CW4-1:0]        code_x10;
  logic [CODE_W-1:0]     code_next;
  logic [COORD_BITS-1:0] mag_ext, num_value;
  logic                  num_start;
  logic [1:0]            num_axis;
  phase_e                num_body;
  verdict_e              line_verdict;

  // Saturating decimal accumulate: x*10 + d, clipped at all ones.
  assign line_x10  = ({4'b0, line_q} << 3) + ({4'b0, line_q} << 1) + LW4'(tok_i.digit);
  assign line_next = (line_x10 > {4'b0, {LINE_BITS{1'b1}}}) ? {LINE_BITS{1'b1}}
                                                             : line_x10[LINE_BITS-1:0];
  assign mag_x10   = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + MW4'(tok_i.digit);
  assign mag_next  = (mag_x10 > {4'b0, {MAG_W{1'b1}}}) ? {MAG_W{1'b1}} : mag_x10[MAG_W-1:0];
  assign code_x10  = ({4'b0, code_q} << 3) + ({4'b0, code_q} << 1) + CW4'(tok_i.digit);
  assign code_next = (code_x10 > {4'b0, {CODE_W{1'b1}}}) ? {CODE_W{1'b1}}
                                                          : code_x10[CODE_W-1:0];

  assign mag_ext   = {1'b0, mag_q};
  assign num_value = minus_q ? (COORD_BITS'(0) - mag_ext) : mag_ext;

  // A line end needs a free result slot; everything else drains freely.
  assign take = tok_valid_i &&
                (halted_q || tok_i.kind != TK_EOL || !out_valid_q || res_ready_i);
  assign tok_pop_o = take;

  always_comb begin
    num_start = 1'b0;
    num_axis  = 2'd0;
    num_body  = PH_X_BODY;
    unique case (phase_q) inside
      PH_X_START: begin num_start = 1'b1; num_axis = 2'd0; num_body = PH_X_BODY; end
      PH_X_BODY:  begin num_axis = 2'd0; num_body = PH_X_BODY; end
      PH_Y_START: begin num_start = 1'b1; num_axis = 2'd1; num_body = PH_Y_BODY; end
      PH_Y_BODY:  begin num_axis = 2'd1; num_body = PH_Y_BODY; end
      PH_Z_START: begin num_start = 1'b1; num_axis = 2'd2; num_body = PH_Z_BODY; end
      PH_Z_BODY:  begin num_axis = 2'd2; num_body = PH_Z_BODY; end
      default: begin
        num_axis = 2'd0;
      end
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    line_d    = line_q;
    last_d    = last_q;
    code_d    = code_q;
    mag_d     = mag_q;
    minus_d   = minus_q;
    point_d   = point_q;
    frac_d    = frac_q;
    hx_d      = hx_q;
    hy_d      = hy_q;
    gap_d     = gap_q;
    verdict_d = verdict_q;
    halted_d  = halted_q;

    out_load      = 1'b0;
    out_verdict_d = out_verdict_q;
    out_line_d    = out_line_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_z_d       = out_z_q;
    out_gap_d     = out_gap_q;
    line_verdict  = V_INVALID;

    if (take && !halted_q) begin
      unique case (phase_q) inside
        PH_EXP_N: begin
          if (tok_i.kind == TK_N) begin
            phase_d = PH_N_FIRST;
          end else begin
            verdict_d = V_STOP;
            phase_d   = PH_SKIP;
          end
        end
        PH_N_FIRST, PH_N_MORE: begin
          if (tok_i.kind == TK_DIGIT) begin
            line_d  = line_next;
            phase_d = PH_N_MORE;
          end else if (phase_q == PH_N_FIRST) begin
            verdict_d = V_STOP;
            phase_d   = PH_SKIP;
          end else begin
            gap_d = ({1'b0, line_q} != ({1'b0, last_q} + (LINE_BITS + 1)'(1)));
            if (tok_i.kind == TK_G) begin
              phase_d = PH_G_FIRST;
            end else begin
              verdict_d = V_STOP;
              phase_d   = PH_SKIP;
            end
          end
        end
        PH_G_FIRST, PH_G_MORE: begin
          if (tok_i.kind == TK_DIGIT) begin
            code_d  = code_next;
            phase_d = PH_G_MORE;
          end else if (phase_q == PH_G_FIRST || code_q != CODE_LINEAR) begin
            verdict_d = V_STOP;
            phase_d   = PH_SKIP;
          end else begin
            // The header is good: this line now counts as accepted.
            last_d = line_q;
            if (tok_i.kind == TK_X) begin
              mag_d   = '0;
              minus_d = 1'b0;
              point_d = 1'b0;
              frac_d  = '0;
              phase_d = PH_X_START;
            end else begin
              verdict_d = V_INVALID;
              phase_d   = PH_SKIP;
            end
          end
        end
        PH_X_START, PH_X_BODY, PH_Y_START, PH_Y_BODY, PH_Z_START, PH_Z_BODY: begin
          if (tok_i.kind == TK_DIGIT) begin
            mag_d = mag_next;
            if (point_q && frac_q != FRAC_SAT) begin
              frac_d = frac_q + 1'b1;
            end
            phase_d = num_body;
          end else if (tok_i.kind == TK_MINUS) begin
            if (!num_start) begin
              verdict_d = V_INVALID;
              phase_d   = PH_SKIP;
            end else begin
              minus_d = 1'b1;
              phase_d = num_body;
            end
          end else if (tok_i.kind == TK_POINT) begin
            if (num_start || point_q) begin
              verdict_d = V_INVALID;
              phase_d   = PH_SKIP;
            end else begin
              point_d = 1'b1;
            end
          end else if (frac_q != FRAC_NEEDED) begin
            verdict_d = V_INVALID;
            phase_d   = PH_SKIP;
          end else if (num_axis == 2'd0) begin
            hx_d = num_value;
            if (tok_i.kind == TK_Y) begin
              mag_d   = '0;
              minus_d = 1'b0;
              point_d = 1'b0;
              frac_d  = '0;
              phase_d = PH_Y_START;
            end else begin
              verdict_d = V_INVALID;
              phase_d   = PH_SKIP;
            end
          end else if (num_axis == 2'd1) begin
            hy_d = num_value;
            if (tok_i.kind == TK_Z) begin
              mag_d   = '0;
              minus_d = 1'b0;
              point_d = 1'b0;
              frac_d  = '0;
              phase_d = PH_Z_START;
            end else begin
              verdict_d = V_INVALID;
              phase_d   = PH_SKIP;
            end
          end else begin
            phase_d = PH_Z_DONE;
          end
        end
        default: begin
          // Trailing text after Z, or the rest of a decided line.
          phase_d = phase_q;
        end
      endcase

      if (tok_i.kind == TK_EOL) begin
        if (phase_d == PH_Z_DONE) begin
          line_verdict = V_MOVE;
        end else if (phase_d == PH_SKIP && verdict_d != V_UNDECIDED) begin
          line_verdict = verdict_d;
        end else begin
          line_verdict = V_INVALID;
        end
        out_load      = 1'b1;
        out_verdict_d = line_verdict;
        out_line_d    = line_d;
        out_x_d       = (line_verdict == V_MOVE) ? hx_d : '0;
        out_y_d       = (line_verdict == V_MOVE) ? hy_d : '0;
        out_z_d       = (line_verdict == V_MOVE) ? num_value : '0;
        out_gap_d     = gap_d;

        phase_d   = PH_EXP_N;
        line_d    = '0;
        code_d    = '0;
        mag_d     = '0;
        minus_d   = 1'b0;
        point_d   = 1'b0;
        frac_d    = '0;
        hx_d      = '0;
        hy_d      = '0;
        gap_d     = 1'b0;
        verdict_d = V_UNDECIDED;
        if (line_verdict == V_STOP) begin
          halted_d = 1'b1;
        end
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_EXP_N;
      line_q      <= '0;
      last_q      <= '0;
      code_q      <= '0;
      mag_q       <= '0;
      minus_q     <= 1'b0;
      point_q     <= 1'b0;
      frac_q      <= '0;
      hx_q        <= '0;
      hy_q        <= '0;
      gap_q       <= 1'b0;
      verdict_q   <= V_UNDECIDED;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      line_q      <= line_d;
      last_q      <= last_d;
      code_q      <= code_d;
      mag_q       <= mag_d;
      minus_q     <= minus_d;
      point_q     <= point_d;
      frac_q      <= frac_d;
      hx_q        <= hx_d;
      hy_q        <= hy_d;
      gap_q       <= gap_d;
      verdict_q   <= verdict_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_verdict_q <= out_verdict_d;
      out_line_q    <= out_line_d;
      out_x_q       <= out_x_d;
      out_y_q       <= out_y_d;
      out_z_q       <= out_z_d;
      out_gap_q     <= out_gap_d;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_verdict_o = out_verdict_q;
  assign res_line_o    = out_line_q;
  assign res_x_o       = out_x_q;
  assign res_y_o       = out_y_q;
  assign res_z_o       = out_z_q;
  assign res_gap_o     = out_gap_q;

endmodule

@@ hdl/gcode_linear_move_line_parser.sv @@
// ----------------------------------------------------------------------------
// gcode_linear_move_line_parser
// Parses N<digits>G<digits>X<num>Y<num>Z<num> text lines into move results.
// ----------------------------------------------------------------------------
// The block takes one character word per cycle on the slave side, with tlast
// marking a line end (that word carries no character), and sustains one word
// per cycle. Words are classified at once into a four-entry token queue; the
// parser behind it retires one token per cycle; a line end loads its result
// into the output register as the parser takes it. Only a line end waits on
// the master side, and only while the output register is still full. The
// queue absorbs a short stall; once it holds four words, tready drops until
// the result is taken. Each line gives one result word: verdict in tuser
// (move, invalid move, stop), and line number, X, Y, Z in signed thousandths
// and the line-number gap flag in tdata. After a stop the block keeps
// accepting words but discards them until reset.
module gcode_linear_move_line_parser #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned LINE_BITS  = 31
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] character
  input  logic       s_axis_tlast_i,   // line_done

  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  // From bit 0 up: line number, coord_x, coord_y, coord_z, number_gap, zero fill.
  output logic [((LINE_BITS + 3 * COORD_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  output logic [1:0] m_axis_tuser_o    // [1:0] verdict
);
  import glmp_pkg::*;

  localparam int unsigned RAW_W = LINE_BITS + 3 * COORD_BITS + 1;
  localparam int unsigned OUT_W = ((RAW_W + 7) / 8) * 8;

  token_t                cls_tok, q_tok;
  logic                  cls_push, q_full, q_valid, q_pop;
  verdict_e              res_verdict;
  logic [LINE_BITS-1:0]  res_line;
  logic [COORD_BITS-1:0] res_x, res_y, res_z;
  logic                  res_gap;
  logic [RAW_W-1:0]      res_raw;

  glmp_classify u_classify (
    .char_valid_i (s_axis_tvalid_i),
    .char_i       (s_axis_tdata_i),
    .line_done_i  (s_axis_tlast_i),
    .queue_full_i (q_full),
    .char_ready_o (s_axis_tready_o),
    .tok_push_o   (cls_push),
    .tok_o        (cls_tok)
  );

  glmp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cls_push),
    .push_tok_i (cls_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_tok_o  (q_tok)
  );

  glmp_exec #(
    .COORD_BITS (COORD_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (q_valid),
    .tok_i         (q_tok),
    .tok_pop_o     (q_pop),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .res_verdict_o (res_verdict),
    .res_line_o    (res_line),
    .res_x_o       (res_x),
    .res_y_o       (res_y),
    .res_z_o       (res_z),
    .res_gap_o     (res_gap)
  );

  assign res_raw        = {res_gap, res_z, res_y, res_x, res_line};
  assign m_axis_tdata_o = OUT_W'(res_raw);
  assign m_axis_tuser_o = res_verdict;

endmodule
